// ===== sv/wmh64_pkg.sv =====
// Package for the word-mixing 64-bit hash: mixing constants, microcode
// field types, step addresses and the microcode ROM. No dependencies.
package wmh64_pkg;

  localparam logic [63:0] K1 = 64'h9e3779b185ebca87;
  localparam logic [63:0] K2 = 64'hc2b2ae3d27d4eb4f;
  localparam logic [63:0] K3 = 64'h165667b19e3779f9;
  localparam logic [63:0] K4 = 64'h27d4eb2f165667c5;
  localparam logic [63:0] K5 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] K6 = 64'hc4ceb9fe1a85ec53;

  localparam int unsigned WordBytes = 8;

  typedef logic [4:0] step_t;

  // Multiplier partial product taken in a step.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_op_t;

  // Constant used as the second multiplier operand.
  typedef enum logic [1:0] {
    KS_1,
    KS_2,
    KS_4,
    KS_5
  } ksel_t;

  // Update of the multiplier operand register.
  typedef enum logic [2:0] {
    X_HOLD,
    X_LEN,
    X_INPUT,
    X_ROT31,
    X_ROT23,
    X_HSHIFT,
    X_PSHIFT,
    X_K6
  } x_op_t;

  // Update of the running hash register.
  typedef enum logic [1:0] {
    H_HOLD,
    H_SEED,
    H_ADD3,
    H_LOAD_P
  } h_op_t;

  // Sequencing of the step counter.
  typedef enum logic [2:0] {
    F_NEXT,
    F_WAIT_ITEM,
    F_DISPATCH,
    F_END_ITEM,
    F_JUMP,
    F_EMIT
  } flow_t;

  typedef struct packed {
    mul_op_t mul;
    ksel_t   ksel;
    logic    k_is_6;
    x_op_t   xop;
    h_op_t   hop;
    flow_t   flow;
    step_t   target;
  } ucode_t;

  // Step addresses of the program.
  localparam step_t S_IDLE  = 5'd0;
  localparam step_t S_SEED  = 5'd1;
  localparam step_t S_DISP  = 5'd5;
  localparam step_t S_WORD  = 5'd6;
  localparam step_t S_BYTE  = 5'd14;
  localparam step_t S_FIN   = 5'd21;
  localparam step_t S_EMIT  = 5'd29;

  function automatic logic [63:0] kval(ksel_t sel, logic is_6);
    logic [63:0] k;
    case (sel)
      KS_1:    k = K1;
      KS_2:    k = K2;
      KS_4:    k = K4;
      KS_5:    k = K5;
      default: k = K1;
    endcase
    return is_6 ? K6 : k;
  endfunction

  // One control word per step. A multiply by a 64-bit constant modulo 2^64
  // takes three steps: low by low, low by high, high by low; a byte skips the last.
  function automatic ucode_t ucode_rom(step_t a);
    ucode_t u;
    case (a)
      // Wait for a transaction; the length register is parked in x.
      5'd0:  u = '{MUL_NONE, KS_1, 1'b0, X_LEN,    H_HOLD,   F_WAIT_ITEM, S_IDLE};
      // Seed: h = K1 ^ (length * K2).
      5'd1:  u = '{MUL_LL,   KS_2, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd2:  u = '{MUL_LH,   KS_2, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd3:  u = '{MUL_HL,   KS_2, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd4:  u = '{MUL_NONE, KS_1, 1'b0, X_HOLD,   H_SEED,   F_NEXT,      S_IDLE};
      // Dispatch on the byte count and the tail byte index.
      5'd5:  u = '{MUL_NONE, KS_1, 1'b0, X_INPUT,  H_HOLD,   F_DISPATCH,  S_IDLE};
      // Full word.
      5'd6:  u = '{MUL_LL,   KS_1, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd7:  u = '{MUL_LH,   KS_1, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd8:  u = '{MUL_HL,   KS_1, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd9:  u = '{MUL_NONE, KS_1, 1'b0, X_ROT31,  H_HOLD,   F_NEXT,      S_IDLE};
      5'd10: u = '{MUL_LL,   KS_2, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd11: u = '{MUL_LH,   KS_2, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd12: u = '{MUL_HL,   KS_2, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd13: u = '{MUL_NONE, KS_1, 1'b0, X_HOLD,   H_ADD3,   F_END_ITEM,  S_IDLE};
      // One tail byte; the byte operand has no upper half.
      5'd14: u = '{MUL_LL,   KS_4, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd15: u = '{MUL_LH,   KS_4, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd16: u = '{MUL_NONE, KS_1, 1'b0, X_ROT23,  H_HOLD,   F_NEXT,      S_IDLE};
      5'd17: u = '{MUL_LL,   KS_1, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd18: u = '{MUL_LH,   KS_1, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd19: u = '{MUL_HL,   KS_1, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd20: u = '{MUL_NONE, KS_1, 1'b0, X_HOLD,   H_LOAD_P, F_JUMP,      S_DISP};
      // Finalizer.
      5'd21: u = '{MUL_NONE, KS_1, 1'b0, X_HSHIFT, H_HOLD,   F_NEXT,      S_IDLE};
      5'd22: u = '{MUL_LL,   KS_5, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd23: u = '{MUL_LH,   KS_5, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd24: u = '{MUL_HL,   KS_5, 1'b0, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd25: u = '{MUL_NONE, KS_1, 1'b0, X_PSHIFT, H_HOLD,   F_NEXT,      S_IDLE};
      5'd26: u = '{MUL_LL,   KS_1, 1'b1, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd27: u = '{MUL_LH,   KS_1, 1'b1, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd28: u = '{MUL_HL,   KS_1, 1'b1, X_HOLD,   H_HOLD,   F_NEXT,      S_IDLE};
      5'd29: u = '{MUL_NONE, KS_1, 1'b0, X_HOLD,   H_HOLD,   F_EMIT,      S_IDLE};
      default: u = '{MUL_NONE, KS_1, 1'b0, X_HOLD, H_HOLD,   F_JUMP,      S_IDLE};
    endcase
    return u;
  endfunction

endpackage

// ===== sv/word_mix_hash64.sv =====
// Word-mixing 64-bit hash engine: a microcoded sequencer around one shared
// 32x32 multiplier. Depends on wmh64_pkg for constants and the microcode ROM.
//
// Usage. Software writes the byte length of the next message through
// cfg_we/cfg_data while the engine is idle; it only enters the seed, which
// is taken when the first transaction of a message arrives. Message words
// then arrive on the item channel (item_valid/item_ready) as word_data with
// byte_count valid bytes from the low end and last_item on the final one.
// Counts above eight act as eight. A full word mixes as a word; a partial
// word mixes byte by byte. On last_item the finalized hash appears on the
// result channel (result_valid/result_ready) as hash_wide and hash_folded.
//
// Timing. A multiply by a 64-bit constant runs as up to three partial
// products through the one multiplier, so the step program sets the rate:
// a full word runs the dispatch and word steps, after the seed steps on the
// first transaction of a message; a partial word runs the byte steps for
// each valid byte. A last transaction adds the finalizer steps before
// result_valid rises. item_ready is high only in the idle step.
//
// Reset clears the step counter, the message flag, the length register and
// the result valid. The result sits in its own register: while it waits on
// result_ready the engine keeps taking and mixing transactions, and stalls
// only in its emit step if a second result is ready before the first left.
module word_mix_hash64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [63:0] word_data,
  input  logic [3:0]  byte_count,
  input  logic        last_item,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] hash_wide,
  output logic [31:0] hash_folded
);

  // Control state.
  wmh64_pkg::step_t   pc, pc_next;
  logic               in_msg, in_msg_next;
  logic               result_valid_next;
  logic [2:0]         idx;
  logic [63:0]        len;

  // Datapath registers; no reset needed.
  logic [63:0]        word;
  logic [3:0]         cnt;
  logic               last_q;
  logic [63:0]        x, x_next;
  logic [63:0]        p, p_next;
  logic [63:0]        h, h_next;
  logic [63:0]        res;

  wmh64_pkg::ucode_t  uc;
  logic               accept;
  logic               emit;
  logic [63:0]        kconst;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [63:0]        hp;
  logic [7:0]         tail_byte;
  logic               full_word;

  assign uc         = wmh64_pkg::ucode_rom(pc);
  assign item_ready = (pc == wmh64_pkg::S_IDLE);
  assign accept     = item_valid && item_ready;
  assign full_word  = (cnt == 4'(wmh64_pkg::WordBytes));
  assign tail_byte  = word[{idx, 3'b000} +: 8];
  assign hp         = h ^ p;
  assign kconst     = wmh64_pkg::kval(uc.ksel, uc.k_is_6);

  // Shared multiplier: one 32x32 partial product per step.
  always_comb begin
    case (uc.mul)
      wmh64_pkg::MUL_LH: begin
        mul_a = x[31:0];
        mul_b = kconst[63:32];
      end
      wmh64_pkg::MUL_HL: begin
        mul_a = x[63:32];
        mul_b = kconst[31:0];
      end
      default: begin
        mul_a = x[31:0];
        mul_b = kconst[31:0];
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Product accumulator. Cross terms only reach the upper half mod 2^64.
  always_comb begin
    case (uc.mul)
      wmh64_pkg::MUL_LL: p_next = prod;
      wmh64_pkg::MUL_LH: p_next = p + {prod[31:0], 32'h0};
      wmh64_pkg::MUL_HL: p_next = p + {prod[31:0], 32'h0};
      default:           p_next = p;
    endcase
  end

  // Multiplier operand register.
  always_comb begin
    case (uc.xop)
      wmh64_pkg::X_LEN:    x_next = len;
      wmh64_pkg::X_INPUT:  x_next = full_word ? word : {56'h0, tail_byte};
      wmh64_pkg::X_ROT31:  x_next = {hp[32:0], hp[63:33]};
      wmh64_pkg::X_ROT23:  x_next = {hp[40:0], hp[63:41]};
      wmh64_pkg::X_HSHIFT: x_next = h ^ {33'h0, h[63:33]};
      wmh64_pkg::X_PSHIFT: x_next = p ^ {33'h0, p[63:33]};
      default:             x_next = x;
    endcase
  end

  // Running hash register.
  always_comb begin
    case (uc.hop)
      wmh64_pkg::H_SEED:   h_next = wmh64_pkg::K1 ^ p;
      wmh64_pkg::H_ADD3:   h_next = p + wmh64_pkg::K3;
      wmh64_pkg::H_LOAD_P: h_next = p;
      default:             h_next = h;
    endcase
  end

  // Step sequencing and handshake control.
  always_comb begin
    pc_next           = pc + 5'd1;
    in_msg_next       = in_msg;
    emit              = 1'b0;
    result_valid_next = result_valid && !result_ready;
    case (uc.flow)
      wmh64_pkg::F_WAIT_ITEM: begin
        if (!accept) begin
          pc_next = wmh64_pkg::S_IDLE;
        end else if (in_msg) begin
          pc_next = wmh64_pkg::S_DISP;
        end else begin
          pc_next     = wmh64_pkg::S_SEED;
          in_msg_next = 1'b1;
        end
      end
      wmh64_pkg::F_DISPATCH: begin
        if (full_word) begin
          pc_next = wmh64_pkg::S_WORD;
        end else if ({1'b0, idx} < cnt) begin
          pc_next = wmh64_pkg::S_BYTE;
        end else if (last_q) begin
          pc_next = wmh64_pkg::S_FIN;
        end else begin
          pc_next = wmh64_pkg::S_IDLE;
        end
      end
      wmh64_pkg::F_END_ITEM: begin
        pc_next = last_q ? wmh64_pkg::S_FIN : wmh64_pkg::S_IDLE;
      end
      wmh64_pkg::F_JUMP: begin
        pc_next = uc.target;
      end
      wmh64_pkg::F_EMIT: begin
        if (!result_valid || result_ready) begin
          emit              = 1'b1;
          result_valid_next = 1'b1;
          in_msg_next       = 1'b0;
          pc_next           = wmh64_pkg::S_IDLE;
        end else begin
          pc_next = wmh64_pkg::S_EMIT;
        end
      end
      default: begin
        pc_next = pc + 5'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= wmh64_pkg::S_IDLE;
      in_msg       <= 1'b0;
      result_valid <= 1'b0;
      len          <= 64'h0;
      idx          <= 3'd0;
    end else begin
      pc           <= pc_next;
      in_msg       <= in_msg_next;
      result_valid <= result_valid_next;
      if (cfg_we) begin
        len <= cfg_data;
      end
      // The tail byte index advances when a byte has been folded in.
      if (accept) begin
        idx <= 3'd0;
      end else if (uc.xop == wmh64_pkg::X_ROT23) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    p <= p_next;
    h <= h_next;
    if (accept) begin
      word   <= word_data;
      cnt    <= byte_count[3] ? 4'(wmh64_pkg::WordBytes) : byte_count;
      last_q <= last_item;
    end
    if (emit) begin
      res <= p ^ {33'h0, p[63:33]};
    end
  end

  assign hash_wide   = res;
  assign hash_folded = res[63:32] ^ res[31:0];

endmodule

// ===== sv/wmh64_checker.sv =====
// Port-level checker for word_mix_hash64 and the bind that attaches it.
// Depends only on the top level's ports.
module wmh64_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [63:0] hash_wide,
  input logic [31:0] hash_folded
);

  // A stalled result keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(hash_wide))
    else $error("stalled result changed");

  // The folded hash always matches the wide hash.
  a_fold: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> hash_folded == (hash_wide[63:32] ^ hash_wide[31:0]))
    else $error("folded hash mismatch");

  // The engine is busy right after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("ready right after a transaction");

  // Finalization runs its own steps, so no result follows at once.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !result_valid |=> !result_valid)
    else $error("result appeared too early");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind word_mix_hash64 wmh64_checker u_wmh64_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .hash_wide    (hash_wide),
  .hash_folded  (hash_folded)
);
